[sv/sms_pkg.sv]
// Shared types and constants for the sorted matrix staircase search block.
package sms_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int DATA_W = 32;
  localparam int CFG_W = 7;
  localparam int IDX_W = 6;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 1;

  // Register indexes, taken from paddr above the byte offset.
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // Request codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Read port that holds the entry under the walk.
  localparam logic SEL_LEFT = 1'b0;
  localparam logic SEL_DOWN = 1'b1;

  typedef struct packed {
    logic wr_en;  // store the entry of the accepted write transaction
    logic load;   // capture the target and place the walk at the corner
    logic prime;  // fetch the corner entry
    logic step;   // move one column left or one row down
  } sms_cmd_t;

  typedef struct packed {
    logic active;  // current position lies inside the region in use
    logic hit;     // current entry equals the target
  } sms_sts_t;

endpackage

[sv/sms_dp.sv]
// Datapath of the staircase search: matrix memory, walk position and compare.
module sms_dp
  import sms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sms_cmd_t                 cmd_i,
  input  logic [CFG_W-1:0]         row_count_i,
  input  logic [CFG_W-1:0]         col_count_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] search_target_i,
  output sms_sts_t                 sts_o
);

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [ADDR_W-1:0] row,
                                                 input logic [ADDR_W-1:0] col);
    return row * ADDR_W'(MAX_COLS) + col;
  endfunction

  logic signed [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic signed [DATA_W-1:0] rd_left_q, rd_down_q;
  logic signed [DATA_W-1:0] target_q;
  logic [RCNT_W-1:0]        row_q, row_d;
  logic [CCNT_W-1:0]        cnext_q, cnext_d;
  logic                     sel_q, sel_d;

  logic [RCNT_W-1:0] rows_sat, row_inc;
  logic [CCNT_W-1:0] cols_sat, col_cur, col_left;
  logic [ADDR_W-1:0] addr_left, addr_down, addr_wr;
  logic              wr_ok;
  logic signed [DATA_W-1:0] cur;

  assign rows_sat = (32'(row_count_i) > 32'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS)
                                                       : RCNT_W'(row_count_i);
  assign cols_sat = (32'(col_count_i) > 32'(MAX_COLS)) ? CCNT_W'(MAX_COLS)
                                                       : CCNT_W'(col_count_i);

  assign row_inc  = row_q + 1'b1;
  assign col_cur  = cnext_q - 1'b1;
  assign col_left = cmd_i.prime ? col_cur : (cnext_q - CCNT_W'(2));

  assign addr_left = mem_addr(ADDR_W'(row_q), ADDR_W'(col_left));
  assign addr_down = mem_addr(ADDR_W'(row_inc), ADDR_W'(col_cur));
  assign addr_wr   = mem_addr(ADDR_W'(row_index_i), ADDR_W'(col_index_i));
  assign wr_ok     = (32'(row_index_i) < 32'(MAX_ROWS)) &&
                     (32'(col_index_i) < 32'(MAX_COLS));

  assign cur = (sel_q == SEL_DOWN) ? rd_down_q : rd_left_q;

  assign sts_o.active = (row_q < rows_sat) && (cnext_q != '0);
  assign sts_o.hit    = sts_o.active && (cur == target_q);

  always_comb begin
    row_d   = row_q;
    cnext_d = cnext_q;
    sel_d   = sel_q;
    if (cmd_i.load) begin
      row_d   = '0;
      cnext_d = cols_sat;
    end else if (cmd_i.prime) begin
      sel_d = SEL_LEFT;
    end else if (cmd_i.step) begin
      if (cur > target_q) begin
        cnext_d = col_cur;
        sel_d   = SEL_LEFT;
      end else begin
        row_d = row_inc;
        sel_d = SEL_DOWN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      cnext_q <= '0;
      sel_q   <= SEL_LEFT;
    end else begin
      row_q   <= row_d;
      cnext_q <= cnext_d;
      sel_q   <= sel_d;
    end
  end

  // Both neighbors of the current entry are fetched every cycle; the step
  // decision picks one of them in the next cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem_q[addr_wr] <= entry_value_i;
    end
    rd_left_q <= mem_q[addr_left];
    rd_down_q <= mem_q[addr_down];
    if (cmd_i.load) begin
      target_q <= search_target_i;
    end
  end

endmodule

[sv/sms_ctrl.sv]
// Controller of the staircase search: transaction handshakes and walk sequencing.
module sms_ctrl
  import sms_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     req_type_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output logic     found_o,
  input  sms_sts_t sts_i,
  output sms_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   found_q, found_d;
  logic   pend_q, pend_d;
  logic   accept, slot_free, finish;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign finish      = (state_q == ST_WALK) && (!sts_i.active || sts_i.hit);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

  always_comb begin
    cmd_o.wr_en = accept && (req_type_i == REQ_WRITE);
    cmd_o.load  = accept && (req_type_i == REQ_SEARCH);
    cmd_o.prime = (state_q == ST_PRIME);
    cmd_o.step  = (state_q == ST_WALK) && !finish;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    pend_d      = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (finish) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            found_d     = sts_i.hit;
            state_d     = ST_IDLE;
          end else begin
            pend_d  = sts_i.hit;
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          found_d     = pend_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      pend_q      <= pend_d;
    end
  end

  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_WALK || $past(state_q) == ST_HOLD))
    else $error("result raised without a finished search");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |=> (state_q == ST_IDLE))
    else $error("write transaction started a search");

  a_search_primes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_PRIME))
    else $error("search transaction did not fetch the corner entry");

  a_hold_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q)
    else $error("result parked while the output register was free");

endmodule

[sv/sorted_matrix_staircase_search.sv]
// Top level of the sorted matrix staircase search: register port and wiring.
//
// The block keeps a matrix of signed 32-bit entries, up to 64 rows by 64
// columns, with rows and columns each sorted ascending. Input transactions
// arrive on in_valid_i/in_stall_o. A write transaction (req_type_i low)
// stores entry_value_i at row_index_i, col_index_i in one cycle and gives
// no result. A search transaction (req_type_i high) walks from the top-right
// corner of the region in use, one column left when the entry exceeds the
// target and one row down otherwise, and returns one result transaction on
// out_valid_o/out_stall_i with found_o set when an equal entry was met.
// A search first fetches the corner entry, then steps through the visited
// entries and concludes by loading the result. The walk is set by the
// memory read loop: both neighbors of the current entry are read each
// cycle and the compare picks one. One transaction is worked on at a time;
// a new one is accepted while an earlier result still waits in the output
// register. When the receiver stalls, a finished search parks its answer
// until the register frees. Reset clears the counts and the handshake
// state; matrix contents are undefined until written. row_count and
// col_count sit at byte addresses 0 and 4 of the register port; the user
// must write them only while the block is idle, which the block itself
// does not enforce.
module sorted_matrix_staircase_search
  import sms_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic signed [DATA_W-1:0] search_target_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o
);

  logic [CFG_W-1:0]     row_count_q, row_count_d;
  logic [CFG_W-1:0]     col_count_q, col_count_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  sms_cmd_t             cmd;
  sms_sts_t             sts;

  // The register port never waits; the byte offset bits of paddr are ignored.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    prdata      = '0;
    unique case (reg_idx)
      REG_ROW_COUNT: begin
        prdata = PDATA_W'(row_count_q);
        if (reg_wr) begin
          row_count_d = pwdata[CFG_W-1:0];
        end
      end
      REG_COL_COUNT: begin
        prdata = PDATA_W'(col_count_q);
        if (reg_wr) begin
          col_count_d = pwdata[CFG_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      col_count_q <= '0;
    end else begin
      row_count_q <= row_count_d;
      col_count_q <= col_count_d;
    end
  end

  // The controller owns both handshakes and the output register.
  sms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the matrix, the walk position and the target.
  sms_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .row_count_i     (row_count_q),
    .col_count_i     (col_count_q),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .entry_value_i   (entry_value_i),
    .search_target_i (search_target_i),
    .sts_o           (sts)
  );

endmodule

[verif/sorted_matrix_staircase_search_test.sv]
// Self-checking testbench for the sorted matrix staircase search block.
module sorted_matrix_staircase_search_test;
  import sms_pkg::*;

  // Run shape. The settle time after the last result covers a full-size walk
  // with margin.
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int MAX_REPORTS = 10;
  localparam int SCRIPT_LEN = 22;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // One input transaction as the block sees it.
  typedef struct packed {
    logic                     req;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] target;
  } matrix_req_t;

  // One line of the directed script. When set_size is high the counts are
  // reprogrammed (with the block idle) before the transaction is offered. When
  // typed is high the answer is written in the table instead of predicted.
  typedef struct {
    bit               set_size;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    matrix_req_t      item;
    bit               typed;
    logic             want_found;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     req_type = REQ_WRITE;
  logic [IDX_W-1:0]         row_index = '0;
  logic [IDX_W-1:0]         col_index = '0;
  logic signed [DATA_W-1:0] entry_value = '0;
  logic signed [DATA_W-1:0] search_target = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;

  // Our own copy of the block's state: the matrix and the two counts.
  logic signed [DATA_W-1:0] cells [MAX_ROWS][MAX_COLS];
  logic [CFG_W-1:0]         row_cnt = '0;
  logic [CFG_W-1:0]         col_cnt = '0;

  // Answers still owed by the block, oldest first.
  logic found_q [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  random_items = 0;
  bit  no_gaps = 1'b0;
  bit  hold_request = 1'b0;

  // Directed script. It starts with the counts at their reset value of zero,
  // builds a sorted 2x2 matrix holding both extreme values, searches the
  // corner, the extremes, present and absent values, then a write outside the
  // region in use, empty regions in both directions (including counts far
  // above the store size), and a walk over contents that are no longer
  // sorted. Unused fields carry odd values throughout.
  directed_row_t script [SCRIPT_LEN] = '{
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  32'sd0},        1'b1, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd63, 6'd63, VAL_MAX, VAL_MIN},       1'b1, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_WRITE,  6'd0,  6'd0,  VAL_MIN, VAL_MAX},       1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_WRITE,  6'd0,  6'd1,  32'sd0,  -32'sd1},       1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_WRITE,  6'd1,  6'd0,  32'sd5,  32'sd0},        1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_WRITE,  6'd1,  6'd1,  VAL_MAX, VAL_MIN},       1'b0, 1'b0},
    '{1'b1, 7'd2,   7'd2,   '{REQ_SEARCH, 6'd0,  6'd0,  VAL_MIN, 32'sd0},        1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd63, 6'd0,  32'sd0,  VAL_MAX},       1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd0,  6'd63, VAL_MAX, VAL_MIN},       1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd21, 6'd42, -32'sd1, 32'sd5},        1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd42, 6'd21, 32'sd7,  32'sd3},        1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd1,  6'd1,  32'sd0,  -32'sd1},       1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  VAL_MAX - 1},   1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_WRITE,  6'd63, 6'd63, VAL_MAX, 32'sd5},        1'b0, 1'b0},
    '{1'b1, 7'd0,   7'd2,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  32'sd0},        1'b1, 1'b0},
    '{1'b1, 7'd2,   7'd0,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  32'sd5},        1'b1, 1'b0},
    '{1'b1, 7'd127, 7'd0,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  VAL_MIN},       1'b1, 1'b0},
    '{1'b1, 7'd0,   7'd127, '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  VAL_MAX},       1'b1, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_WRITE,  6'd0,  6'd1,  VAL_MAX, 32'sd0},        1'b0, 1'b0},
    '{1'b1, 7'd2,   7'd2,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  32'sd5},        1'b0, 1'b0},
    '{1'b0, 7'd0,   7'd0,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  32'sd0},        1'b0, 1'b0},
    '{1'b1, 7'd1,   7'd1,   '{REQ_SEARCH, 6'd0,  6'd0,  32'sd0,  VAL_MIN},       1'b0, 1'b0}
  };

  sorted_matrix_staircase_search i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .row_index_i     (row_index),
    .col_index_i     (col_index),
    .entry_value_i   (entry_value),
    .search_target_i (search_target),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .found_o         (found)
  );

  always #5 clk = ~clk;

  // Counts clipped to the store size, as the walk uses them.
  function automatic int rows_in_use();
    return (row_cnt > MAX_ROWS) ? MAX_ROWS : int'(row_cnt);
  endfunction

  function automatic int cols_in_use();
    return (col_cnt > MAX_COLS) ? MAX_COLS : int'(col_cnt);
  endfunction

  // Staircase walk from the top-right corner of the region in use: a larger
  // entry sends the walk one column left, a smaller one a row down.
  function automatic logic staircase_lookup(input logic signed [DATA_W-1:0] target);
    int rows;
    int r;
    int c;
    rows = rows_in_use();
    r = 0;
    c = cols_in_use() - 1;
    while (r < rows && c >= 0) begin
      if (cells[r][c] == target) return 1'b1;
      if (cells[r][c] > target) c--;
      else r++;
    end
    return 1'b0;
  endfunction

  // Applies an accepted transaction to our copy of the state and records
  // the answer a search must produce.
  function automatic void apply_request(input matrix_req_t rq, input bit typed,
                                        input logic typed_found);
    if (rq.req == REQ_WRITE) begin
      if (rq.row < MAX_ROWS && rq.col < MAX_COLS) cells[rq.row][rq.col] = rq.value;
    end else begin
      found_q.push_back(typed ? typed_found : staircase_lookup(rq.target));
    end
  endfunction

  function automatic void log_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Offers one transaction after a random gap, or none when no_gaps is set, and returns
  // at the rising edge where it was taken. Valid stays high across back-to-back transactions.
  task automatic offer_request(input matrix_req_t rq, input bit typed,
                               input logic typed_found);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rq.req;
    row_index     <= rq.row;
    col_index     <= rq.col;
    entry_value   <= rq.value;
    search_target <= rq.target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(rq, typed, typed_found);
  endtask

  // Drops valid and waits until every owed answer has come back, then lets
  // a full walk's worth of cycles pass so nothing is left in flight.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready. The upper
  // data bits carry noise since only the low count bits are kept.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] word;
    word = $urandom;
    word[CFG_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_counts(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    quiesce();
    write_register(REG_ROW_COUNT, rows);
    row_cnt = rows;
    write_register(REG_COL_COUNT, cols);
    col_cnt = cols;
  endtask

  // One random phase: program the size, fill the whole region in use with a
  // freshly sorted matrix (so no unwritten entry is ever walked over), then
  // run a mix of searches and stray writes.
  task automatic run_phase(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                           input int searches);
    matrix_req_t rq;
    longint      base;
    longint      up;
    longint      lf;
    longint      v;
    int          step_max;
    int          er;
    int          ec;
    int          pick;
    int          r;
    int          c;
    set_counts(rows, cols);
    er = rows_in_use();
    ec = cols_in_use();
    // Step size decides whether values repeat, spread out, or pile up at the
    // top of the range.
    case ($urandom_range(0, 3))
      0: begin base = longint'(int'($urandom)); step_max = 2; end
      1: begin base = longint'(int'($urandom)); step_max = 1000; end
      2: begin base = longint'(VAL_MIN); step_max = 1 << 26; end
      default: begin base = longint'(VAL_MIN); step_max = 1 << 30; end
    endcase
    for (int fr = 0; fr < er; fr++) begin
      for (int fc = 0; fc < ec; fc++) begin
        up = (fr > 0) ? longint'(cells[fr-1][fc]) : base;
        lf = (fc > 0) ? longint'(cells[fr][fc-1]) : base;
        v = ((up > lf) ? up : lf) + longint'($urandom_range(0, step_max));
        if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
        rq.req    = REQ_WRITE;
        rq.row    = IDX_W'(fr);
        rq.col    = IDX_W'(fc);
        rq.value  = v[DATA_W-1:0];
        rq.target = $urandom;
        offer_request(rq, 1'b0, 1'b0);
        random_items++;
      end
    end
    for (int n = 0; n < searches; n++) begin
      rq.row    = IDX_W'($urandom);
      rq.col    = IDX_W'($urandom);
      rq.value  = $urandom;
      rq.target = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Stray write: mostly anywhere in the store, sometimes right inside
        // the region in use so the matrix stops being sorted.
        rq.req = REQ_WRITE;
        if (pick < 3 && er > 0 && ec > 0) begin
          rq.row = IDX_W'($urandom_range(0, er - 1));
          rq.col = IDX_W'($urandom_range(0, ec - 1));
        end
      end else begin
        rq.req = REQ_SEARCH;
        if (er > 0 && ec > 0) begin
          r = $urandom_range(0, er - 1);
          c = $urandom_range(0, ec - 1);
          if (pick < 50) rq.target = cells[r][c];
          else if (pick < 60) rq.target = cells[r][c] + 32'sd1;
          else if (pick < 70) rq.target = cells[r][c] - 32'sd1;
          else if (pick < 95) rq.target = (pick < 90) ? rq.target : VAL_MIN;
          else rq.target = VAL_MAX;
        end
      end
      offer_request(rq, 1'b0, 1'b0);
      random_items++;
    end
  endtask

  // Result side: for every result it waits a random number of cycles with
  // stall high, or once a long stretch when asked, so the block backs up.
  initial begin : result_sink
    int hold;
    forever begin
      if (hold_request) begin
        hold = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 5);
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Every accepted result is checked against the oldest owed answer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (found_q.size() == 0) begin
        log_failure($sformatf("result %0d arrived with none owed (found=%b)",
                              results_seen, found));
      end else if (found !== found_q[0]) begin
        log_failure($sformatf("result %0d found: expected %b, got %b",
                              results_seen, found_q[0], found));
        void'(found_q.pop_front());
      end else begin
        void'(found_q.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sorted_matrix_staircase_search: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int rows;
    int cols;
    int pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script[i].set_size) set_counts(script[i].rows, script[i].cols);
      offer_request(script[i].item, script[i].typed, script[i].want_found);
    end

    // Size extremes first: a full column, a full row, counts well above
    // the store size that must be clipped, and an empty region.
    run_phase(7'd64, 7'd1, 30);
    run_phase(7'd1, 7'd64, 30);
    run_phase(7'd127, 7'd1, 20);
    run_phase(7'd1, 7'd127, 20);
    run_phase(7'd0, 7'd0, 10);

    // Back-pressure phase: the sink holds off while the source keeps
    // offering searches, so the output register fills and input stalls.
    no_gaps = 1'b1;
    hold_request = 1'b1;
    run_phase(7'd4, 7'd4, 60);
    no_gaps = 1'b0;

    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Empty region in one direction, any count in the other.
        rows = $urandom_range(0, 1) ? 0 : $urandom_range(0, 127);
        cols = (rows == 0) ? $urandom_range(0, 127) : 0;
      end else if (pick == 1) begin
        rows = $urandom_range(1, 24);
        cols = $urandom_range(1, 24);
      end else begin
        rows = $urandom_range(1, 8);
        cols = $urandom_range(1, 8);
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      run_phase(CFG_W'(rows), CFG_W'(cols), $urandom_range(20, 50));
    end
    no_gaps = 1'b0;

    quiesce();
    if (mismatches == 0 && found_q.size() == 0) begin
      $display("** sorted_matrix_staircase_search: PASSED **");
    end else begin
      $display("** sorted_matrix_staircase_search: FAILED **");
    end
    $finish;
  end

endmodule
